[rtl/bldc_pkg.sv]
package bldc_pkg;

  localparam int DUTY_BITS     = 8;
  localparam int PERIOD_BITS   = 16;
  localparam int HOLD_BITS     = 17;
  localparam int CFG_DATA_BITS = HOLD_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int STEP_BITS     = 3;
  localparam int GATE_BITS     = 6;

  localparam logic [PERIOD_BITS-1:0] START_PERIOD_RST    = PERIOD_BITS'(5000);
  localparam logic [PERIOD_BITS-1:0] END_PERIOD_RST      = PERIOD_BITS'(100);
  localparam logic [PERIOD_BITS-1:0] PERIOD_STEP_RST     = PERIOD_BITS'(20);
  localparam logic [DUTY_BITS-1:0]   START_DUTY_RST      = DUTY_BITS'(100);
  localparam logic [DUTY_BITS-1:0]   MIN_DUTY_RST        = DUTY_BITS'(50);
  localparam logic [DUTY_BITS-1:0]   MAX_DUTY_RST        = DUTY_BITS'(255);
  localparam logic [HOLD_BITS-1:0]   ADJUST_INTERVAL_RST = HOLD_BITS'(100000);

  // gate bits: 5 uh, 4 ul, 3 vh, 2 vl, 1 wh, 0 wl
  localparam logic [GATE_BITS-1:0] GATES_OFF = 6'h00;
  localparam logic [GATE_BITS-1:0] G_UH_VL   = 6'h24;
  localparam logic [GATE_BITS-1:0] G_UH_WL   = 6'h21;
  localparam logic [GATE_BITS-1:0] G_VH_WL   = 6'h09;
  localparam logic [GATE_BITS-1:0] G_VH_UL   = 6'h18;
  localparam logic [GATE_BITS-1:0] G_WH_UL   = 6'h12;
  localparam logic [GATE_BITS-1:0] G_WH_VL   = 6'h06;

  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(5);

  localparam logic [2:0] HALL_ALL_LOW  = 3'b000;
  localparam logic [2:0] HALL_ALL_HIGH = 3'b111;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_START_PERIOD,
    REG_END_PERIOD,
    REG_PERIOD_STEP,
    REG_START_DUTY,
    REG_MIN_DUTY,
    REG_MAX_DUTY,
    REG_ADJUST_INTERVAL
  } cfg_reg_t;

  typedef struct packed {
    logic hall_u;
    logic hall_v;
    logic hall_w;
    logic accel_push;
    logic accel_release;
  } in_item_t;

  typedef struct packed {
    logic                 gate_uh;
    logic                 gate_ul;
    logic                 gate_vh;
    logic                 gate_vl;
    logic                 gate_wh;
    logic                 gate_wl;
    logic [DUTY_BITS-1:0] duty_out;
    logic                 running;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_BITS-1:0]  reg_index;
    logic [CFG_DATA_BITS-1:0] data;
  } cfg_req_t;

  // open-loop sequence; codes past the last step wrap as step mod 6
  function automatic logic [GATE_BITS-1:0] ramp_gates(input logic [STEP_BITS-1:0] step);
    logic [GATE_BITS-1:0] g;
    case (step)
      3'd0:    g = G_UH_VL;
      3'd1:    g = G_UH_WL;
      3'd2:    g = G_VH_WL;
      3'd3:    g = G_VH_UL;
      3'd4:    g = G_WH_UL;
      3'd5:    g = G_WH_VL;
      3'd6:    g = G_UH_VL;
      default: g = G_UH_WL;
    endcase
    return g;
  endfunction

  // hall code {u,v,w}; the two invalid codes are filtered by the caller
  function automatic logic [GATE_BITS-1:0] hall_gates(input logic [2:0] code);
    logic [GATE_BITS-1:0] g;
    case (code)
      3'd1:    g = G_UH_WL;
      3'd2:    g = G_VH_UL;
      3'd3:    g = G_VH_WL;
      3'd4:    g = G_WH_VL;
      3'd5:    g = G_UH_VL;
      3'd6:    g = G_WH_UL;
      default: g = GATES_OFF;
    endcase
    return g;
  endfunction

endpackage

[rtl/bldc_stream_if.sv]
interface bldc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/bldc_six_step_commutator_unit.sv]
// The result of an accepted request is registered and shows in the next cycle.
// Throughput: one request per cycle; the input takes a new request while the
// result register is empty or being drained in the same cycle.
// Reset (rst_n, synchronous): registers return to defaults, ramp restarts,
// gates off, result register empty. Config writes are registered and never stalled.
module bldc_six_step_commutator_unit (
  input  logic         clk,
  input  logic         rst_n,
  bldc_stream_if.sink   in_ch,
  bldc_stream_if.source out_ch,
  bldc_stream_if.sink   cfg_ch
);
  import bldc_pkg::*;

  // configuration
  logic [PERIOD_BITS-1:0] end_period_r, period_step_r;
  logic [DUTY_BITS-1:0]   start_duty_r, min_duty_r, max_duty_r;
  logic [HOLD_BITS-1:0]   adjust_interval_r;

  // working state
  logic                   run_r, run_nxt;
  logic [PERIOD_BITS-1:0] ramp_period_r, ramp_period_nxt;
  logic [PERIOD_BITS-1:0] ramp_count_r, ramp_count_nxt;
  logic [STEP_BITS-1:0]   step_r, step_nxt;
  logic [GATE_BITS-1:0]   gates_r, gates_nxt;
  logic [DUTY_BITS-1:0]   duty_r, duty_nxt;
  logic [HOLD_BITS-1:0]   hold_r, hold_nxt;

  // result register
  logic                   out_valid_r;
  out_item_t              out_item_r, out_item_nxt;

  in_item_t               req;
  cfg_req_t               cfg;
  logic                   accept, cfg_wr;
  logic                   enter_run;
  logic [DUTY_BITS-1:0]   duty_base, shown_src, shown;
  logic [HOLD_BITS-1:0]   hold_base, hold_dec;
  logic [PERIOD_BITS-1:0] count_inc;
  logic [2:0]             hall_code;

  assign req    = in_ch.payload;
  assign cfg    = cfg_ch.payload;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign accept = in_ch.valid && in_ch.ready;
  assign cfg_wr = cfg_ch.valid;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_item_r;

  always_comb begin
    enter_run       = !run_r && (ramp_period_r <= end_period_r);
    run_nxt         = run_r || enter_run;
    duty_base       = enter_run ? start_duty_r : duty_r;
    hold_base       = enter_run ? '0 : hold_r;
    hold_dec        = (hold_base != '0) ? hold_base - HOLD_BITS'(1) : hold_base;
    hall_code       = {req.hall_u, req.hall_v, req.hall_w};
    count_inc       = ramp_count_r + PERIOD_BITS'(1);

    duty_nxt        = duty_r;
    hold_nxt        = hold_r;
    gates_nxt       = gates_r;
    step_nxt        = step_r;
    ramp_count_nxt  = ramp_count_r;
    ramp_period_nxt = ramp_period_r;
    shown_src       = start_duty_r;

    if (run_nxt) begin
      duty_nxt = duty_base;
      hold_nxt = hold_dec;
      if (hold_dec == '0) begin
        if (req.accel_push && !req.accel_release && duty_base < max_duty_r) begin
          duty_nxt = duty_base + DUTY_BITS'(1);
          hold_nxt = adjust_interval_r;
        end else if (req.accel_release && !req.accel_push && duty_base > min_duty_r) begin
          duty_nxt = duty_base - DUTY_BITS'(1);
          hold_nxt = adjust_interval_r;
        end
      end
      if (hall_code != HALL_ALL_LOW && hall_code != HALL_ALL_HIGH) begin
        gates_nxt = hall_gates(hall_code);
      end
      shown_src = duty_nxt;
    end else begin
      ramp_count_nxt = count_inc;
      if (count_inc >= ramp_period_r) begin
        gates_nxt       = ramp_gates(step_r);
        step_nxt        = (step_r >= LAST_STEP) ? '0 : step_r + STEP_BITS'(1);
        ramp_count_nxt  = '0;
        ramp_period_nxt = (ramp_period_r > period_step_r) ?
                          ramp_period_r - period_step_r : '0;
      end
    end

    // lower limit first, upper limit wins when they cross
    shown = shown_src;
    if (shown < min_duty_r) shown = min_duty_r;
    if (shown > max_duty_r) shown = max_duty_r;

    out_item_nxt.gate_uh  = gates_nxt[5];
    out_item_nxt.gate_ul  = gates_nxt[4];
    out_item_nxt.gate_vh  = gates_nxt[3];
    out_item_nxt.gate_vl  = gates_nxt[2];
    out_item_nxt.gate_wh  = gates_nxt[1];
    out_item_nxt.gate_wl  = gates_nxt[0];
    out_item_nxt.duty_out = shown;
    out_item_nxt.running  = run_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_period_r      <= END_PERIOD_RST;
      period_step_r     <= PERIOD_STEP_RST;
      start_duty_r      <= START_DUTY_RST;
      min_duty_r        <= MIN_DUTY_RST;
      max_duty_r        <= MAX_DUTY_RST;
      adjust_interval_r <= ADJUST_INTERVAL_RST;
      run_r             <= 1'b0;
      ramp_period_r     <= START_PERIOD_RST;
      ramp_count_r      <= '0;
      step_r            <= '0;
      gates_r           <= GATES_OFF;
      duty_r            <= START_DUTY_RST;
      hold_r            <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (accept) begin
        run_r         <= run_nxt;
        ramp_period_r <= ramp_period_nxt;
        ramp_count_r  <= ramp_count_nxt;
        step_r        <= step_nxt;
        gates_r       <= gates_nxt;
        duty_r        <= duty_nxt;
        hold_r        <= hold_nxt;
      end else if (cfg_wr) begin
        // ramp-mode side effects of a register write
        if (!run_r && cfg_reg_t'(cfg.reg_index) == REG_START_PERIOD) begin
          ramp_period_r <= cfg.data[PERIOD_BITS-1:0];
          ramp_count_r  <= '0;
        end
        if (!run_r && cfg_reg_t'(cfg.reg_index) == REG_START_DUTY) begin
          duty_r <= cfg.data[DUTY_BITS-1:0];
        end
      end

      if (cfg_wr) begin
        unique case (cfg_reg_t'(cfg.reg_index))
          // start period only reloads the ramp timing, handled above
          REG_START_PERIOD:    ;
          REG_END_PERIOD:      end_period_r      <= cfg.data[PERIOD_BITS-1:0];
          REG_PERIOD_STEP:     period_step_r     <= cfg.data[PERIOD_BITS-1:0];
          REG_START_DUTY:      start_duty_r      <= cfg.data[DUTY_BITS-1:0];
          REG_MIN_DUTY:        min_duty_r        <= cfg.data[DUTY_BITS-1:0];
          REG_MAX_DUTY:        max_duty_r        <= cfg.data[DUTY_BITS-1:0];
          REG_ADJUST_INTERVAL: adjust_interval_r <= cfg.data[HOLD_BITS-1:0];
          default:             ;
        endcase
      end

      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

endmodule
